// ----- hdl/asbs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asbs_pkg: shared definitions for the additive sine bank synthesiser
// Holds the default sizes, the fixed-point constants, the input kind codes,
// the divider status bundle and the sine polynomial used to build the table.
// ---------------------------------------------------------------------------
package asbs_pkg;

  // Default sizes of the oscillator bank and of the sine table.
  localparam int ROWS_DEFAULT       = 256;
  localparam int SINE_DEPTH_DEFAULT = 1024;

  // Phase advance per sample tick: 0.01 rad expressed in turns of 2^32.
  localparam logic [31:0] PHASE_STEP = 32'd6835653;

  // Fixed-point constants for the sine table (Q2.30).
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Full-scale pixel amplitude.
  localparam logic [7:0] AMP_MAX = 8'd255;

  // Width of the rounded quotient; the magnitude of a sample never exceeds 32767.
  localparam int QUOT_W = 15;

  // Input kind codes.
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Magnitude of sin(x) scaled to 32767, x in Q2.30 within the first quarter wave.
  // Odd Taylor series to x^11 in Horner form with truncating steps.
  function automatic logic [15:0] sine_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    p  = ONE_Q30 - x2 / 64'd110;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd72;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd42;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd20;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd6;
    s  = (x * p) >> 30;
    s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

endpackage

// ----- hdl/asbs_sine_rom.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asbs_sine_rom: Q1.15 sine table with a registered read
// The table is built at elaboration, one entry per phase step of a full turn,
// by folding each angle into the first quarter wave.
// ---------------------------------------------------------------------------
module asbs_sine_rom #(
  parameter int SINE_TABLE_DEPTH = asbs_pkg::SINE_DEPTH_DEFAULT,
  localparam int IW = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic [IW-1:0]       idx,
  output logic signed [15:0]  sine
);

  logic signed [15:0] rom_val [SINE_TABLE_DEPTH];

  // Build each entry from its quarter-wave position.
  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_entry
    localparam logic [63:0] N4   = 64'(4 * g);
    localparam logic [63:0] QUAD = N4 / SINE_TABLE_DEPTH;
    localparam logic [63:0] REM0 = N4 - QUAD * SINE_TABLE_DEPTH;
    localparam logic [63:0] REMF = (QUAD % 2 == 1) ? (SINE_TABLE_DEPTH - REM0) : REM0;
    localparam logic [63:0] XQ30 = REMF * asbs_pkg::HALF_PI_Q30 / SINE_TABLE_DEPTH;
    localparam logic [15:0] MAG  = asbs_pkg::sine_poly(XQ30);
    localparam logic [15:0] VAL  = (QUAD >= 2) ? (16'd0 - MAG) : MAG;
    assign rom_val[g] = VAL;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    sine <= rom_val[idx];
  end

endmodule

// ----- hdl/asbs_round_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asbs_round_div: rounding divider by 255 times the row count
// Half the divisor is added up front so that the quotient is rounded to
// nearest, ties away from zero. A reciprocal multiplication gives an estimate
// that is at most one low, and a multiply-back and compare puts it right.
// The numerator, the reciprocal product, the multiply-back and the corrected quotient are each registered.
// ---------------------------------------------------------------------------
module asbs_round_div #(
  parameter int ROWS = asbs_pkg::ROWS_DEFAULT,
  parameter int NW   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [NW-1:0]                dividend,
  output asbs_pkg::div_status_t        status,
  output logic [asbs_pkg::QUOT_W-1:0]  quotient
);

  localparam int QW      = asbs_pkg::QUOT_W;
  // The divisor and its reciprocal both fit in 18 bits for up to 1024 rows.
  localparam int DW      = 18;
  localparam int MW      = 18;
  localparam int DIVISOR = 255 * ROWS;
  localparam int HALF    = DIVISOR / 2;
  localparam logic [NW-1:0] DIV_VAL = NW'(DIVISOR);
  localparam logic [DW-1:0] DIV_D   = DW'(DIVISOR);
  localparam logic [MW-1:0] RECIP   = MW'((64'd1 << NW) / 64'(DIVISOR));

  logic [2:0]       stage;
  logic             done;
  logic [NW-1:0]    num;
  logic [NW+MW-1:0] prod;
  logic [QW-1:0]    est_w;
  logic [QW-1:0]    est;
  logic [QW+DW-1:0] back;
  logic [NW-1:0]    rem;

  // The estimate is the product scaled back down; the remainder tells
  // whether it fell one short.
  assign est_w  = prod[NW +: QW];
  assign rem    = num - NW'(back);
  assign status = '{busy: (|stage), done: done};

  // Control: one flag per step, done pulses as the quotient is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  // Datapath: rounded numerator, reciprocal product, multiply-back, correction.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend + NW'(HALF);
    end
    if (stage[0]) begin
      prod <= (NW + MW)'(num) * (NW + MW)'(RECIP);
    end
    if (stage[1]) begin
      est  <= est_w;
      back <= (QW + DW)'(est_w) * (QW + DW)'(DIV_D);
    end
    if (stage[2]) begin
      quotient <= (rem >= DIV_VAL) ? (est + 1'b1) : est;
    end
  end

endmodule

// ----- hdl/additive_sine_bank_synth.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// additive_sine_bank_synth: additive synthesis oscillator bank
// Stores a column of 8-bit pixel amplitudes and, per sample tick, sums one
// sine partial per row through a shared multiply-accumulate pipeline.
//
//   Channel   Signals                                  Dir  Meaning
//   in        in_valid, in_ready, kind, row_index,     in   pixel write or
//             pixel_value                                   sample tick
//   out       out_valid, out_ready, sample_out         out  Q1.15 audio sample
//   cfg       cfg_valid, cfg_ready, cfg_data           in   invert_mode write
//
// A pixel write is taken while idle. A sample tick walks one row per cycle
// through the shared multiply-accumulate, drains its pipeline, passes the
// reciprocal rounding divider and then loads the output register.
// After reset all min(ROWS, 256) entries of the pixel store are cleared,
// and no transaction is taken on the input channel until that is done.
// The result sits in an output register; pixel writes and the next tick are
// taken while it waits, and a finished sample waits only for that register.
// ---------------------------------------------------------------------------
module additive_sine_bank_synth #(
  parameter int ROWS             = asbs_pkg::ROWS_DEFAULT,
  parameter int SINE_TABLE_DEPTH = asbs_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         row_index,
  input  logic [7:0]         pixel_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  // Only rows addressable by an 8-bit index are stored; the rest stay zero.
  localparam int STORE_DEPTH = (ROWS < 256) ? ROWS : 256;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int RW          = $clog2(ROWS);
  localparam int IW          = $clog2(SINE_TABLE_DEPTH);
  localparam int ACC_W       = 24 + $clog2(ROWS);
  localparam int QW          = asbs_pkg::QUOT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t state;

  logic             invert_mode;
  logic [31:0]      time_phase;
  logic [AW-1:0]    clr_addr;
  logic [RW-1:0]    row;
  logic [1:0]       mod3;
  logic [1:0]       mod3_next;
  logic [31:0]      ph;
  logic [31:0]      ph_next;
  logic             acc_neg;

  logic [7:0]       pixel_store [STORE_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       pix_rd;

  logic             accept;
  logic             accept_sample;
  logic             wr_in_range;
  logic             drain_done;

  logic [32+IW:0]   idx_prod;
  logic             s1_valid;
  logic             s1_in_range;
  logic [IW-1:0]    s1_idx;
  logic             s2_valid;
  logic [7:0]       s2_amp;
  logic signed [15:0] s2_sine;
  logic             s3_valid;
  logic signed [24:0] s3_prod;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_mag;

  logic             div_start;
  asbs_pkg::div_status_t div_status;
  logic [QW-1:0]    quotient;
  logic [15:0]      quot_ext;

  // Handshakes.
  assign in_ready      = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = in_valid && in_ready;
  assign accept_sample = accept && (kind == asbs_pkg::KIND_SAMPLE);
  assign wr_in_range   = ({1'b0, row_index} < 9'(STORE_DEPTH));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      invert_mode <= cfg_data;
    end
  end

  // Pixel store write port: the clearing sweep or a pixel write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'd0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && (kind == asbs_pkg::KIND_PIXEL) && wr_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = row_index[AW-1:0];
      mem_wdata = pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[mem_waddr] <= mem_wdata;
    end
  end

  // Row walk runs from the last row down, so that k = (ROWS - row) div 3
  // rises by one every third row and the partial phase k * t is a running sum.
  assign mod3_next = (mod3 == 2'd2) ? 2'd0 : (mod3 + 2'd1);
  assign ph_next   = (mod3_next == 2'd0) ? (ph + time_phase) : ph;
  assign drain_done = !s1_valid && !s2_valid && !s3_valid;
  assign div_start  = (state == ST_DRAIN) && drain_done;

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      time_phase <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The register empties on a transaction unless a new sample takes its place.
      if (out_valid && out_ready && (state != ST_HOLD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept_sample) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (row == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            time_phase <= time_phase + asbs_pkg::PHASE_STEP;
            state      <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            sample_out <= acc_neg ? (16'sd0 - $signed(quot_ext)) : $signed(quot_ext);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Row counter, mod-3 counter and partial phase.
  always_ff @(posedge clk) begin
    if (accept_sample) begin
      row  <= RW'(ROWS - 1);
      mod3 <= 2'd1;
      ph   <= '0;
    end else if (state == ST_RUN) begin
      row  <= row - 1'b1;
      mod3 <= mod3_next;
      ph   <= ph_next;
    end
  end

  // Stage 1: table index from the phase, pixel read.
  assign idx_prod = {{(IW + 1){1'b0}}, ph} * (33 + IW)'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    s1_idx      <= idx_prod[32 +: IW];
    s1_in_range <= ({{(32 - RW){1'b0}}, row} < 32'(STORE_DEPTH));
    pix_rd      <= pixel_store[row[AW-1:0]];
  end

  // Stage 2: sine value and amplitude.
  asbs_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .idx  (s1_idx),
    .sine (s2_sine)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (invert_mode) begin
      s2_amp <= asbs_pkg::AMP_MAX - (s1_in_range ? pix_rd : 8'd0);
    end else begin
      s2_amp <= s1_in_range ? pix_rd : 8'd0;
    end
  end

  // Stage 3: the shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_prod <= $signed({1'b0, s2_amp}) * s2_sine;
  end

  // Stage 4: accumulator, cleared as a sample tick is taken.
  always_ff @(posedge clk) begin
    if (accept_sample) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= acc + ACC_W'(s3_prod);
    end
  end

  // Sign and magnitude for the divider.
  assign acc_mag = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;

  always_ff @(posedge clk) begin
    if (div_start) begin
      acc_neg <= acc[ACC_W-1];
    end
  end

  // Rounded division by 255 * ROWS; the quotient stays below 32768.
  asbs_round_div #(
    .ROWS (ROWS),
    .NW   (ACC_W)
  ) u_round_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag),
    .status   (div_status),
    .quotient (quotient)
  );

  assign quot_ext = {1'b0, quotient};

  // The divider is never running while the block can take a transaction.
  a_div_idle : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_status.busy)
    else $error("divider busy while idle");

  // A sample tick only starts with the multiply-accumulate pipeline empty.
  a_pipe_empty : assert property (@(posedge clk) disable iff (rst)
    accept_sample |-> (!s1_valid && !s2_valid && !s3_valid))
    else $error("sample accepted with partials in flight");

  // The phase moves only when a sample finishes its accumulation.
  a_phase_hold : assert property (@(posedge clk) disable iff (rst)
    !div_start |=> $stable(time_phase))
    else $error("time phase changed outside a sample");

  // The result is loaded only after the divider has finished.
  a_hold_ready : assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> (!div_status.busy && !s3_valid))
    else $error("result held while work is in flight");

endmodule
